/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the deframer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hw/rtl/lfrd_pkg.sv */
// Types and constants of the link frame record deframer
package lfrd_pkg;

	localparam int unsigned POS_W  = 11;
	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QPTR_W = 2;
	localparam int unsigned QCNT_W = 3;

	localparam logic [POS_W-1:0] POS_TOTAL_HI  = 11'd8;
	localparam logic [POS_W-1:0] POS_TOTAL_LO  = 11'd9;
	localparam logic [POS_W-1:0] POS_SEQ_FIRST = 11'd10;
	localparam logic [POS_W-1:0] RECORDS_MIN   = 11'd14;
	localparam logic [POS_W-1:0] POS_MAX       = 11'd2047;
	localparam logic [1:0]       REC_HEADER    = 2'd3;

	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_ID      = 3'd1;
	localparam logic [2:0] PH_LEN_HI  = 3'd2;
	localparam logic [2:0] PH_LEN_LO  = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_SKIP    = 3'd5;
	localparam logic [2:0] PH_STOP    = 3'd6;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;
	localparam logic [1:0] KIND_TICK    = 2'd3;

	localparam logic [1:0] ST_NEVER  = 2'd0;
	localparam logic [1:0] ST_ACTIVE = 2'd1;
	localparam logic [1:0] ST_TIMEOUT = 2'd2;

	localparam logic FUNC_BYTE = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	localparam logic [1:0] REG_AREA_START = 2'd0;
	localparam logic [1:0] REG_ID_LIMIT   = 2'd1;
	localparam logic [1:0] REG_SIL_STEP   = 2'd2;
	localparam logic [1:0] REG_SIL_LIMIT  = 2'd3;

	localparam logic [9:0]  AREA_START_RST = 10'd16;
	localparam logic [8:0]  ID_LIMIT_RST   = 9'd64;
	localparam logic [15:0] SIL_STEP_RST   = 16'd5;
	localparam logic [15:0] SIL_LIMIT_RST  = 16'd10150;

	typedef struct packed {
		logic [9:0]  area_start;
		logic [8:0]  id_limit;
		logic [15:0] sil_step;
		logic [15:0] sil_limit;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  record_id;
		logic [15:0] payload_length;
		logic [7:0]  payload_byte;
		logic        record_done;
		logic [31:0] sequence_number;
		logic [1:0]  link_status;
		logic        run_last;
	} res_t;

	typedef struct packed {
		logic [1:0] n;
		res_t       r0;
		res_t       r1;
	} push_t;

endpackage

/* hw/rtl/lfrd_frame_if.sv */
// Input channel: frame bytes and failed-read ticks
interface lfrd_frame_if;
	logic       valid;
	logic       ready;
	logic       func;
	logic [7:0] frame_byte;
	logic       frame_end;

	modport source (output valid, output func, output frame_byte, output frame_end,
		input ready);
	modport sink (input valid, input func, input frame_byte, input frame_end,
		output ready);
endinterface

/* hw/rtl/lfrd_result_if.sv */
// Result channel: record headers, payload bytes, frame done and tick status
interface lfrd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  record_id;
	logic [15:0] payload_length;
	logic [7:0]  payload_byte;
	logic        record_done;
	logic [31:0] sequence_number;
	logic [1:0]  link_status;
	logic        run_last;

	modport source (output valid, output kind, output record_id, output payload_length,
		output payload_byte, output record_done, output sequence_number,
		output link_status, output run_last, input ready);
	modport sink (input valid, input kind, input record_id, input payload_length,
		input payload_byte, input record_done, input sequence_number,
		input link_status, input run_last, output ready);
endinterface

/* hw/rtl/link_frame_record_deframer_unit.sv */
// Top level of the link frame record deframer with its register port
//
//  channel  dir  handshake     beat
//  frame    in   valid/ready   func, frame_byte, frame_end
//  result   out  valid/ready   kind, ids, lengths, byte, sequence, status, run_last
//  apb      in   psel/penable  four 32-bit registers at byte offsets 0, 4, 8, 12
//
// One beat is taken per cycle while frame.ready is high; its results enter a
// four-entry result queue in the same cycle and leave it one per cycle while
// result.ready is high. frame.ready is high while two or more entries are free.
// Reset clears the parse state, the link status and the queue; registers take
// their defaults. A stalled result holds at the queue head.
module link_frame_record_deframer_unit import lfrd_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	lfrd_frame_if.sink    frame,
	lfrd_result_if.source result,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	cfg_t  cfg_q;
	logic  space_ok;
	push_t push;
	logic  wr;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.area_start <= AREA_START_RST;
			cfg_q.id_limit   <= ID_LIMIT_RST;
			cfg_q.sil_step   <= SIL_STEP_RST;
			cfg_q.sil_limit  <= SIL_LIMIT_RST;
		end else if (wr) begin
			unique case (paddr[3:2])
				REG_AREA_START: cfg_q.area_start <= pwdata[9:0];
				REG_ID_LIMIT:   cfg_q.id_limit   <= pwdata[8:0];
				REG_SIL_STEP:   cfg_q.sil_step   <= pwdata[15:0];
				REG_SIL_LIMIT:  cfg_q.sil_limit  <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_AREA_START: prdata = 32'(cfg_q.area_start);
			REG_ID_LIMIT:   prdata = 32'(cfg_q.id_limit);
			REG_SIL_STEP:   prdata = 32'(cfg_q.sil_step);
			REG_SIL_LIMIT:  prdata = 32'(cfg_q.sil_limit);
			default:        prdata = 32'd0;
		endcase
	end

	lfrd_parser #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.space_ok (space_ok),
		.frame    (frame),
		.push     (push)
	);

	lfrd_out_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.result   (result)
	);

endmodule

/* hw/rtl/lfrd_parser.sv */
// Frame parser: header fields, record walk, link status and silence counter
`include "assert_macros.svh"
module lfrd_parser import lfrd_pkg::*; #(
	parameter int unsigned FRAME_BYTES = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  cfg_t          cfg,
	input  logic          space_ok,
	lfrd_frame_if.sink    frame,
	output push_t         push
);

	logic             acc;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [15:0]      total_q, total_d;
	logic [31:0]      seq_q, seq_d;
	logic [POS_W-1:0] nrs_q, nrs_d;
	logic [2:0]       phase_q, phase_d;
	logic [7:0]       id_q, id_d;
	logic [15:0]      len_q, len_d;
	logic [15:0]      rem_q, rem_d;
	logic [1:0]       status_q, status_d;
	logic [15:0]      sil_q, sil_d;

	logic             in_range, at_last;
	logic [15:0]      len_new, rem_dec, fin_len, room;
	logic [16:0]      need, sil_sum;
	logic [17:0]      nxt;
	logic             fin_stop, keep;
	logic [POS_W-1:0] area_start;
	logic             r_valid, r_done;
	logic [1:0]       r_kind;
	logic [7:0]       r_data;

	assign frame.ready = space_ok;
	assign acc = frame.valid && space_ok;

	assign in_range = {1'b0, pos_q} < 12'(FRAME_BYTES);
	assign at_last  = {1'b0, pos_q} == 12'(FRAME_BYTES - 1);
	assign len_new  = {len_q[15:8], frame.frame_byte};
	assign rem_dec  = rem_q - 16'd1;
	assign fin_len  = (phase_q == PH_LEN_LO) ? len_new : len_q;
	assign nxt      = 18'(nrs_q) + 18'(REC_HEADER) + 18'(fin_len);
	assign fin_stop = nxt >= {2'b00, total_q};
	assign room     = total_q - 16'(nrs_q);
	assign need     = 17'(REC_HEADER) + {1'b0, len_new};
	assign keep     = {1'b0, id_q} < cfg.id_limit;
	assign area_start = ({1'b0, cfg.area_start} < RECORDS_MIN) ? RECORDS_MIN
		: {1'b0, cfg.area_start};
	assign sil_sum  = {1'b0, sil_q} + {1'b0, cfg.sil_step};

	always_comb begin
		pos_d    = pos_q;
		total_d  = total_q;
		seq_d    = seq_q;
		nrs_d    = nrs_q;
		phase_d  = phase_q;
		id_d     = id_q;
		len_d    = len_q;
		rem_d    = rem_q;
		status_d = status_q;
		sil_d    = sil_q;
		r_valid  = 1'b0;
		r_kind   = KIND_HEADER;
		r_data   = 8'd0;
		r_done   = 1'b0;

		if (frame.func == FUNC_TICK) begin
			if (status_q == ST_ACTIVE) begin
				if (sil_q < cfg.sil_limit)
					sil_d = sil_sum[16] ? 16'hFFFF : sil_sum[15:0];
				if (sil_d >= cfg.sil_limit)
					status_d = ST_TIMEOUT;
			end
		end else begin
			if (in_range) begin
				case (phase_q)
					PH_HEADER: begin
						if (pos_q == POS_TOTAL_HI)
							total_d = {frame.frame_byte, total_q[7:0]};
						else if (pos_q == POS_TOTAL_LO)
							total_d = {total_q[15:8], frame.frame_byte};
						else if (pos_q >= POS_SEQ_FIRST && pos_q < RECORDS_MIN)
							seq_d = {seq_q[23:0], frame.frame_byte};
						if (pos_q == RECORDS_MIN - 11'd1) begin
							nrs_d   = area_start;
							phase_d = PH_ID;
						end
					end
					PH_ID: begin
						if (pos_q == nrs_q) begin
							if (total_q > 16'(FRAME_BYTES) || 16'(pos_q) >= total_q) begin
								phase_d = PH_STOP;
							end else begin
								id_d    = frame.frame_byte;
								phase_d = PH_LEN_HI;
							end
						end
					end
					PH_LEN_HI: begin
						len_d   = {frame.frame_byte, 8'd0};
						phase_d = PH_LEN_LO;
					end
					PH_LEN_LO: begin
						len_d = len_new;
						if ({1'b0, room} < need) begin
							phase_d = PH_STOP;
						end else begin
							rem_d = len_new;
							if (keep) begin
								r_valid = 1'b1;
								r_kind  = KIND_HEADER;
								r_done  = (len_new == 16'd0);
							end
							if (len_new == 16'd0) begin
								// zero-length record ends at its header
								if (fin_stop) begin
									phase_d = PH_STOP;
								end else begin
									nrs_d   = nxt[POS_W-1:0];
									phase_d = PH_ID;
								end
							end else begin
								phase_d = keep ? PH_PAYLOAD : PH_SKIP;
							end
						end
					end
					PH_PAYLOAD, PH_SKIP: begin
						rem_d = rem_dec;
						if (phase_q == PH_PAYLOAD) begin
							r_valid = 1'b1;
							r_kind  = KIND_PAYLOAD;
							r_data  = frame.frame_byte;
							r_done  = (rem_dec == 16'd0);
						end
						if (rem_dec == 16'd0) begin
							if (fin_stop) begin
								phase_d = PH_STOP;
							end else begin
								nrs_d   = nxt[POS_W-1:0];
								phase_d = PH_ID;
							end
						end
					end
					default: begin
					end
				endcase
				if (at_last)
					phase_d = PH_STOP;
			end
			if (pos_q < POS_MAX)
				pos_d = pos_q + 11'd1;
			if (frame.frame_end) begin
				status_d = ST_ACTIVE;
				sil_d    = 16'd0;
			end
		end
	end

	// Pack the up to two results of this beat, compacted into slot 0 first.
	always_comb begin
		res_t a, d;
		a = '0;
		a.kind           = r_kind;
		a.record_id      = id_d;
		a.payload_length = len_d;
		a.payload_byte   = r_data;
		a.record_done    = r_done;
		a.link_status    = status_d;
		d = '0;
		d.kind            = KIND_DONE;
		d.sequence_number = seq_d;
		d.link_status     = status_d;
		d.run_last        = 1'b1;
		push = '0;
		if (acc) begin
			if (frame.func == FUNC_TICK) begin
				push.n = 2'd1;
				push.r0 = '0;
				push.r0.kind        = KIND_TICK;
				push.r0.link_status = status_d;
				push.r0.run_last    = 1'b1;
			end else if (frame.frame_end && r_valid) begin
				push.n  = 2'd2;
				push.r0 = a;
				push.r1 = d;
			end else if (frame.frame_end) begin
				push.n  = 2'd1;
				push.r0 = d;
			end else if (r_valid) begin
				push.n  = 2'd1;
				push.r0 = a;
				push.r0.run_last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			total_q  <= '0;
			seq_q    <= '0;
			nrs_q    <= '0;
			phase_q  <= PH_HEADER;
			id_q     <= '0;
			len_q    <= '0;
			rem_q    <= '0;
			status_q <= ST_NEVER;
			sil_q    <= '0;
		end else if (acc) begin
			status_q <= status_d;
			sil_q    <= sil_d;
			if (frame.func == FUNC_BYTE && frame.frame_end) begin
				// restart framing for the next frame
				pos_q   <= '0;
				total_q <= '0;
				seq_q   <= '0;
				nrs_q   <= '0;
				phase_q <= PH_HEADER;
				id_q    <= '0;
				len_q   <= '0;
				rem_q   <= '0;
			end else begin
				pos_q   <= pos_d;
				total_q <= total_d;
				seq_q   <= seq_d;
				nrs_q   <= nrs_d;
				phase_q <= phase_d;
				id_q    <= id_d;
				len_q   <= len_d;
				rem_q   <= rem_d;
			end
		end
	end

	`ASSERT_NEXT(a_tick_no_activate, clk, arst_n, acc && frame.func == FUNC_TICK && status_q == ST_NEVER, status_q == ST_NEVER, "tick made a silent link active")
	`ASSERT_NEXT(a_end_restarts, clk, arst_n, acc && frame.func == FUNC_BYTE && frame.frame_end, pos_q == '0 && phase_q == PH_HEADER && status_q == ST_ACTIVE, "frame end did not restart framing")
	`ASSERT_HOLDS(a_payload_left, clk, arst_n, (phase_q != PH_PAYLOAD && phase_q != PH_SKIP) || rem_q != 16'd0, "payload phase with nothing left")

endmodule

/* hw/rtl/lfrd_out_queue.sv */
// Result queue: takes up to two results per beat, delivers one per beat while result.ready is high
`include "assert_macros.svh"
module lfrd_out_queue import lfrd_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  push_t         push,
	output logic          space_ok,
	lfrd_result_if.source result
);

	res_t              ent_q [QDEPTH];
	logic [QPTR_W-1:0] wp_q, rp_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;
	res_t              head;

	assign space_ok = count_q <= QCNT_W'(QDEPTH - 2);
	assign pop      = result.valid && result.ready;
	assign head     = ent_q[rp_q];

	assign result.valid           = count_q != '0;
	assign result.kind            = head.kind;
	assign result.record_id       = head.record_id;
	assign result.payload_length  = head.payload_length;
	assign result.payload_byte    = head.payload_byte;
	assign result.record_done     = head.record_done;
	assign result.sequence_number = head.sequence_number;
	assign result.link_status     = head.link_status;
	assign result.run_last        = head.run_last;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			ent_q[wp_q] <= push.r0;
		if (push.n == 2'd2)
			ent_q[wp_q + QPTR_W'(1)] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + QPTR_W'(push.n);
			if (pop)
				rp_q <= rp_q + QPTR_W'(1);
			count_q <= count_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

	`ASSERT_HOLDS(a_no_overflow, clk, arst_n, count_q <= QCNT_W'(QDEPTH), "result queue overflow")
	`ASSERT_NEXT(a_pop_drains, clk, arst_n, pop && push.n == 2'd0, count_q == $past(count_q) - QCNT_W'(1), "pop did not drain one entry")
	`ASSERT_NEXT(a_head_holds, clk, arst_n, result.valid && !result.ready, $stable(head) && result.valid, "stalled head beat changed")

endmodule
